@@ rtl/tte_pkg.sv @@
`default_nettype none
package tte_pkg;

  localparam logic [1:0] CMD_DRAW   = 2'd0;
  localparam logic [1:0] CMD_SCROLL = 2'd1;
  localparam logic [1:0] CMD_CLEAR  = 2'd2;

  localparam logic [1:0] REG_COLUMNS = 2'd0;
  localparam logic [1:0] REG_ROWS    = 2'd1;
  localparam logic [1:0] REG_WRAP    = 2'd2;

  localparam logic [1:0] MODE_IDLE   = 2'd0;
  localparam logic [1:0] MODE_SEQ    = 2'd1;
  localparam logic [1:0] MODE_DIGITS = 2'd2;

  localparam logic [7:0] COLUMNS_RESET = 8'd80;
  localparam logic [7:0] ROWS_RESET    = 8'd30;
  localparam logic [7:0] WRAP_RESET    = 8'd76;

  localparam logic [7:0] CH_ESC    = 8'h1B;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TILDE  = 8'h7E;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_Z = 8'h5A;
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_LOWER_Z = 8'h7A;
  localparam logic [7:0] CH_BRACKET = 8'h5B;
  localparam logic [7:0] CH_H      = 8'h48;
  localparam logic [7:0] CH_F      = 8'h66;
  localparam logic [7:0] CH_J      = 8'h4A;

  localparam logic [6:0] GLYPH_MAX = 7'd94;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W = $clog2(QUEUE_DEPTH);

  typedef struct packed {
    logic [7:0] columns;
    logic [7:0] rows;
    logic [7:0] wrap_column;
  } tte_cfg_t;

  typedef struct packed {
    logic [7:0] cursor_col;
    logic [7:0] cursor_row;
    logic [1:0] parse_mode;
    logic [1:0] seq_position;
    logic       second_is_bracket;
    logic [1:0] param_count;
    logic [7:0] param_accum;
    logic [7:0] first_param;
    logic [7:0] second_param;
  } tte_state_t;

  typedef struct packed {
    logic [1:0] command;
    logic [7:0] column;
    logic [7:0] row;
    logic [6:0] glyph;
    logic       last;
  } tte_res_t;

  // results of one byte, packed from slot 0
  typedef struct packed {
    logic [1:0] count;
    tte_res_t   res0;
    tte_res_t   res1;
  } tte_batch_t;

endpackage
`default_nettype wire

@@ rtl/tte_step.sv @@
`default_nettype none
module tte_step (
  input  var tte_pkg::tte_cfg_t   cfg,
  input  var tte_pkg::tte_state_t st,
  input  wire logic [7:0]         char_byte,
  output tte_pkg::tte_state_t     st_nxt,
  output tte_pkg::tte_batch_t     batch
);

  tte_pkg::tte_state_t s;
  logic                draw;
  logic                clear;
  logic                scroll;
  logic                is_letter;
  logic                is_digit;
  tte_pkg::tte_res_t   first_res;
  tte_pkg::tte_res_t   scroll_res;

  assign is_letter = char_byte inside {[tte_pkg::CH_UPPER_A:tte_pkg::CH_UPPER_Z],
                                       [tte_pkg::CH_LOWER_A:tte_pkg::CH_LOWER_Z]};
  assign is_digit  = char_byte inside {[tte_pkg::CH_ZERO:tte_pkg::CH_NINE]};

  always_comb begin
    s      = st;
    draw   = 1'b0;
    clear  = 1'b0;
    scroll = 1'b0;

    if (st.parse_mode != tte_pkg::MODE_IDLE) begin
      if (st.seq_position == 2'd1) begin
        s.second_is_bracket = (char_byte == tte_pkg::CH_BRACKET);
      end
      s.seq_position = 2'd2;
      if (is_letter) begin
        if (st.parse_mode == tte_pkg::MODE_DIGITS) begin
          if (st.param_count == 2'd1) begin
            s.first_param = st.param_accum;
          end else if (st.param_count == 2'd2) begin
            s.second_param = st.param_accum;
          end
        end
        if (s.second_is_bracket) begin
          if (char_byte == tte_pkg::CH_H || char_byte == tte_pkg::CH_F) begin
            if (st.param_count == 2'd2) begin
              s.cursor_row = s.first_param - 8'd1;
              s.cursor_col = s.second_param - 8'd1;
            end
            if (s.cursor_col >= cfg.columns) begin
              s.cursor_col = cfg.columns - 8'd1;
            end
            if (s.cursor_row >= cfg.rows) begin
              s.cursor_row = cfg.rows - 8'd1;
            end
          end else if (char_byte == tte_pkg::CH_J) begin
            clear = (st.param_count == 2'd1) && (s.first_param == 8'd2);
          end
        end
        s.parse_mode = tte_pkg::MODE_IDLE;
      end else if (st.parse_mode == tte_pkg::MODE_SEQ && is_digit) begin
        if (st.param_count != 2'd3) begin
          s.param_count = st.param_count + 2'd1;
        end
        s.param_accum = {4'h0, char_byte[3:0]};
        s.parse_mode  = tte_pkg::MODE_DIGITS;
      end else if (st.parse_mode == tte_pkg::MODE_DIGITS && is_digit) begin
        // accum * 10 + digit, mod 256
        s.param_accum = {st.param_accum[4:0], 3'b000} + {st.param_accum[6:0], 1'b0}
                        + {4'h0, char_byte[3:0]};
      end else if (st.parse_mode == tte_pkg::MODE_DIGITS) begin
        if (st.param_count == 2'd1) begin
          s.first_param = st.param_accum;
        end else if (st.param_count == 2'd2) begin
          s.second_param = st.param_accum;
        end
        s.parse_mode = tte_pkg::MODE_SEQ;
      end
    end else if (char_byte inside {[tte_pkg::CH_SPACE:tte_pkg::CH_TILDE]}) begin
      draw         = 1'b1;
      s.cursor_col = st.cursor_col + 8'd1;
    end else if (char_byte == tte_pkg::CH_LF || char_byte == tte_pkg::CH_CR) begin
      s.cursor_row = st.cursor_row + 8'd1;
      s.cursor_col = 8'd0;
    end else if (char_byte == tte_pkg::CH_ESC) begin
      s.parse_mode        = tte_pkg::MODE_SEQ;
      s.seq_position      = 2'd1;
      s.second_is_bracket = 1'b0;
      s.param_count       = 2'd0;
    end

    // per-byte wrap, clamp and scroll
    if (s.cursor_col > cfg.wrap_column) begin
      s.cursor_row = s.cursor_row + 8'd1;
      s.cursor_col = 8'd0;
    end
    if (s.cursor_col >= cfg.columns) begin
      s.cursor_col = cfg.columns - 8'd1;
    end
    if (s.cursor_row >= cfg.rows) begin
      scroll       = 1'b1;
      s.cursor_row = cfg.rows - 8'd1;
    end
  end

  assign st_nxt = s;

  always_comb begin
    first_res = '0;
    if (draw) begin
      first_res.command = tte_pkg::CMD_DRAW;
      first_res.column  = st.cursor_col;
      first_res.row     = st.cursor_row;
      first_res.glyph   = 7'(char_byte - tte_pkg::CH_SPACE);
    end else begin
      first_res.command = tte_pkg::CMD_CLEAR;
    end
    scroll_res         = '0;
    scroll_res.command = tte_pkg::CMD_SCROLL;
    scroll_res.last    = 1'b1;

    batch = '0;
    if (draw || clear) begin
      batch.res0      = first_res;
      batch.res0.last = !scroll;
      batch.res1      = scroll_res;
      batch.count     = scroll ? 2'd2 : 2'd1;
    end else begin
      batch.res0  = scroll_res;
      batch.res1  = scroll_res;
      batch.count = scroll ? 2'd1 : 2'd0;
    end
  end

endmodule
`default_nettype wire

@@ rtl/tte_outq.sv @@
`default_nettype none
module tte_outq (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               push,
  input  var tte_pkg::tte_batch_t batch,
  output logic                    full,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output tte_pkg::tte_res_t       out_res
);

  localparam int CNT_W = tte_pkg::QPTR_W + 1;

  tte_pkg::tte_res_t           mem_r [tte_pkg::QUEUE_DEPTH];
  logic [tte_pkg::QPTR_W-1:0]  head_r;
  logic [tte_pkg::QPTR_W-1:0]  tail_r;
  logic [CNT_W-1:0]            count_r;
  logic [CNT_W-1:0]            count_nxt;
  logic [CNT_W-1:0]            push_n;
  logic                        pop;

  // room for a whole batch must be there before a transaction is taken
  assign full      = count_r > CNT_W'(tte_pkg::QUEUE_DEPTH - 2);
  assign out_valid = count_r != '0;
  assign out_res   = mem_r[head_r];
  assign pop       = out_valid && !out_stall;
  assign push_n    = push ? CNT_W'(batch.count) : '0;
  assign count_nxt = count_r + push_n - CNT_W'(pop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      tail_r  <= '0;
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
      tail_r  <= tail_r + tte_pkg::QPTR_W'(push_n);
      if (pop) begin
        head_r <= head_r + tte_pkg::QPTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push && batch.count != 2'd0) begin
      mem_r[tail_r] <= batch.res0;
    end
    if (push && batch.count == 2'd2) begin
      mem_r[tail_r + tte_pkg::QPTR_W'(1)] <= batch.res1;
    end
  end

endmodule
`default_nettype wire

@@ rtl/text_terminal_escape_engine.sv @@
`default_nettype none
// Character-stream terminal engine: one byte in, zero to two display commands out.
// Input channel: in_valid/in_stall with in_char_byte; a byte is taken at a clock
// edge with in_valid high and in_stall low.
// Result channel: out_valid/out_stall with command, column, row, glyph and last;
// last marks the final command of a byte. A draw or a clear comes before a scroll.
// Results of a byte are registered into the result queue when the byte is taken.
// One byte is taken per cycle while in_stall is low; a byte that makes two commands
// takes two queue entries, so the sustained rate is set by the single output port draining
// a four-entry result queue.
// in_stall rises when fewer than two queue entries are free, so a receiver that
// holds out_stall high stops input after at most four pending commands; nothing
// is lost and a stalled result holds its value.
// cfg_we with cfg_index/cfg_data writes columns, rows or wrap column; write
// only while idle.
// Reset (rst_n low, synchronous): cursor at 0,0, parser idle, queue empty,
// 80 columns, 30 rows, wrap after column 76.
module text_terminal_escape_engine (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] in_char_byte,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [1:0]      out_command,
  output logic [7:0]      out_column,
  output logic [7:0]      out_row,
  output logic [6:0]      out_glyph,
  output logic            out_last,
  input  wire logic       cfg_we,
  input  wire logic [1:0] cfg_index,
  input  wire logic [7:0] cfg_data
);

  tte_pkg::tte_cfg_t   cfg_r;
  tte_pkg::tte_state_t state_r;
  tte_pkg::tte_state_t state_nxt;
  tte_pkg::tte_batch_t batch;
  tte_pkg::tte_res_t   out_res;
  logic                accept;

  assign accept = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.columns     <= tte_pkg::COLUMNS_RESET;
      cfg_r.rows        <= tte_pkg::ROWS_RESET;
      cfg_r.wrap_column <= tte_pkg::WRAP_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        tte_pkg::REG_COLUMNS: cfg_r.columns     <= cfg_data;
        tte_pkg::REG_ROWS:    cfg_r.rows        <= cfg_data;
        tte_pkg::REG_WRAP:    cfg_r.wrap_column <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '0;
    end else if (accept) begin
      state_r <= state_nxt;
    end
  end

  tte_step u_step (
    .cfg       (cfg_r),
    .st        (state_r),
    .char_byte (in_char_byte),
    .st_nxt    (state_nxt),
    .batch     (batch)
  );

  tte_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (accept),
    .batch     (batch),
    .full      (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (out_res)
  );

  assign out_command = out_res.command;
  assign out_column  = out_res.column;
  assign out_row     = out_res.row;
  assign out_glyph   = out_res.glyph;
  assign out_last    = out_res.last;

`ifndef NO_ASSERTIONS
  a_glyph_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_glyph <= tte_pkg::GLYPH_MAX)
    else $error("glyph index out of font range");

  a_non_draw_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_command != tte_pkg::CMD_DRAW)
      |-> (out_column == 8'd0 && out_row == 8'd0 && out_glyph == 7'd0))
    else $error("non-draw command carries position or glyph");

  a_scroll_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_command == tte_pkg::CMD_SCROLL) |-> out_last)
    else $error("scroll is not the final command of its byte");

  a_cmd_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_command == tte_pkg::CMD_DRAW || out_command == tte_pkg::CMD_SCROLL
                   || out_command == tte_pkg::CMD_CLEAR))
    else $error("illegal command code");
`endif

endmodule
`default_nettype wire

@@ test/text_terminal_escape_engine_tb.sv @@
`timescale 1ns / 100ps

module text_terminal_escape_engine_tb;

  localparam int CYCLE_LIMIT = 1000000;
  localparam logic [7:0] CH_SEMI = 8'h3B;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic [7:0] in_char_byte = 8'h00;
  logic       out_stall = 1'b0;
  logic       cfg_we = 1'b0;
  logic [1:0] cfg_index = tte_pkg::REG_COLUMNS;
  logic [7:0] cfg_data = 8'h00;
  wire        in_stall;
  wire        out_valid;
  wire  [1:0] out_command;
  wire  [7:0] out_column;
  wire  [7:0] out_row;
  wire  [6:0] out_glyph;
  wire        out_last;

  text_terminal_escape_engine uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_char_byte(in_char_byte),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_command(out_command),
    .out_column(out_column),
    .out_row(out_row),
    .out_glyph(out_glyph),
    .out_last(out_last),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #4 clk = ~clk;

  // screen settings and terminal state as the block should hold them
  logic [7:0] scr_cols = tte_pkg::COLUMNS_RESET;
  logic [7:0] scr_rows = tte_pkg::ROWS_RESET;
  logic [7:0] wrap_col = tte_pkg::WRAP_RESET;
  logic [7:0] cur_col = 8'd0;
  logic [7:0] cur_row = 8'd0;
  logic [1:0] pmode = tte_pkg::MODE_IDLE;
  logic [1:0] seq_pos = 2'd0;
  logic       after_bracket = 1'b0;
  logic [1:0] n_params = 2'd0;
  logic [7:0] digit_acc = 8'd0;
  logic [7:0] param_a = 8'd0;
  logic [7:0] param_b = 8'd0;

  logic [7:0]        byte_backlog[$];
  tte_pkg::tte_res_t expected_cmds[$];

  bit hold_sender = 1'b0;
  bit idle_on = 1'b1;
  int gap_left = 0;
  int stall_left = 0;
  int n_bytes = 0;
  int n_draws = 0;
  int n_scrolls = 0;
  int n_clears = 0;
  int n_errors = 0;
  int n_settings = 1;
  int cycles = 0;

  function automatic bit is_digit(input logic [7:0] b);
    return b >= tte_pkg::CH_ZERO && b <= tte_pkg::CH_NINE;
  endfunction

  function automatic bit is_letter(input logic [7:0] b);
    return (b >= tte_pkg::CH_UPPER_A && b <= tte_pkg::CH_UPPER_Z) ||
           (b >= tte_pkg::CH_LOWER_A && b <= tte_pkg::CH_LOWER_Z);
  endfunction

  // mostly no gap, sometimes short, rarely long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(11, 40);
  endfunction

  task automatic store_param();
    if (n_params == 2'd1) param_a = digit_acc;
    else if (n_params == 2'd2) param_b = digit_acc;
  endtask

  task automatic predict_commands(input logic [7:0] b);
    tte_pkg::tte_res_t cmds[2];
    int n;
    n = 0;
    cmds[0] = '0;
    cmds[1] = '0;
    if (pmode != tte_pkg::MODE_IDLE) begin
      if (seq_pos == 2'd1) after_bracket = (b == tte_pkg::CH_BRACKET);
      seq_pos = 2'd2;
      if (is_letter(b)) begin
        if (pmode == tte_pkg::MODE_DIGITS) store_param();
        if (after_bracket && (b == tte_pkg::CH_H || b == tte_pkg::CH_F)) begin
          if (n_params == 2'd2) begin
            cur_row = param_a - 8'd1;
            cur_col = param_b - 8'd1;
          end
          if (cur_col >= scr_cols) cur_col = scr_cols - 8'd1;
          if (cur_row >= scr_rows) cur_row = scr_rows - 8'd1;
        end else if (after_bracket && b == tte_pkg::CH_J && n_params == 2'd1 &&
                     param_a == 8'd2) begin
          cmds[n].command = tte_pkg::CMD_CLEAR;
          n++;
        end
        pmode = tte_pkg::MODE_IDLE;
      end else if (pmode == tte_pkg::MODE_SEQ && is_digit(b)) begin
        if (n_params != 2'd3) n_params = n_params + 2'd1;
        digit_acc = b - tte_pkg::CH_ZERO;
        pmode = tte_pkg::MODE_DIGITS;
      end else if (pmode == tte_pkg::MODE_DIGITS && is_digit(b)) begin
        digit_acc = digit_acc * 8'd10 + (b - tte_pkg::CH_ZERO);
      end else if (pmode == tte_pkg::MODE_DIGITS) begin
        store_param();
        pmode = tte_pkg::MODE_SEQ;
      end
    end else if (b >= tte_pkg::CH_SPACE && b <= tte_pkg::CH_TILDE) begin
      cmds[n] = '{tte_pkg::CMD_DRAW, cur_col, cur_row, 7'(b - tte_pkg::CH_SPACE), 1'b0};
      n++;
      cur_col = cur_col + 8'd1;
    end else if (b == tte_pkg::CH_LF || b == tte_pkg::CH_CR) begin
      cur_row = cur_row + 8'd1;
      cur_col = 8'd0;
    end else if (b == tte_pkg::CH_ESC) begin
      pmode = tte_pkg::MODE_SEQ;
      seq_pos = 2'd1;
      after_bracket = 1'b0;
      n_params = 2'd0;
    end

    // checks applied after every byte
    if (cur_col > wrap_col) begin
      cur_row = cur_row + 8'd1;
      cur_col = 8'd0;
    end
    if (cur_col >= scr_cols) cur_col = scr_cols - 8'd1;
    if (cur_row >= scr_rows) begin
      cmds[n].command = tte_pkg::CMD_SCROLL;
      n++;
      cur_row = scr_rows - 8'd1;
    end

    if (n > 0) cmds[n - 1].last = 1'b1;
    for (int i = 0; i < n; i++) expected_cmds.push_back(cmds[i]);
  endtask

  // sender
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      gap_left = 0;
    end else begin
      if (in_valid && !in_stall) predict_commands(in_char_byte);
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (hold_sender || byte_backlog.size() == 0) begin
          in_valid <= 1'b0;
        end else begin
          in_valid <= 1'b1;
          in_char_byte <= byte_backlog.pop_front();
          if (idle_on && $urandom_range(0, 3) == 0) gap_left = pick_gap();
        end
      end
    end
  end

  // receiver and checker
  always @(posedge clk) begin
    tte_pkg::tte_res_t got;
    tte_pkg::tte_res_t want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        got = '{out_command, out_column, out_row, out_glyph, out_last};
        if (expected_cmds.size() == 0) begin
          n_errors++;
          $display("%0t: unexpected command=%0d column=%0d row=%0d glyph=%0d last=%0d",
                   $time, got.command, got.column, got.row, got.glyph, got.last);
        end else begin
          want = expected_cmds.pop_front();
          if (got !== want) begin
            n_errors++;
            $display("%0t: mismatch expected command=%0d column=%0d row=%0d glyph=%0d last=%0d",
                     $time, want.command, want.column, want.row, want.glyph, want.last);
            $display("%0t:          actual command=%0d column=%0d row=%0d glyph=%0d last=%0d",
                     $time, got.command, got.column, got.row, got.glyph, got.last);
          end
          case (want.command)
            tte_pkg::CMD_DRAW:   n_draws++;
            tte_pkg::CMD_SCROLL: n_scrolls++;
            default:             n_clears++;
          endcase
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
        if (idle_on && $urandom_range(0, 3) == 0) stall_left = pick_gap();
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d commands still outstanding",
               cycles, expected_cmds.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic push_byte(input logic [7:0] b);
    byte_backlog.push_back(b);
    n_bytes++;
  endtask

  task automatic push_number(input int value);
    if (value >= 10) push_number(value / 10);
    push_byte(tte_pkg::CH_ZERO + 8'(value % 10));
  endtask

  // mostly well-formed escape sequence with random content
  task automatic push_sequence();
    int np;
    int r;
    logic [7:0] fin;
    push_byte(tte_pkg::CH_ESC);
    if ($urandom_range(0, 9) == 0) push_byte(8'($urandom_range(0, 255)));
    else push_byte(tte_pkg::CH_BRACKET);
    r = $urandom_range(0, 99);
    np = (r < 15) ? 0 : (r < 45) ? 1 : (r < 90) ? 2 : 3;
    r = $urandom_range(0, 99);
    fin = (r < 35) ? tte_pkg::CH_H : (r < 50) ? tte_pkg::CH_F : (r < 80) ? tte_pkg::CH_J :
          (r < 85) ? tte_pkg::CH_UPPER_Z : (r < 90) ? tte_pkg::CH_LOWER_Z :
          ($urandom_range(0, 1) ?
             8'($urandom_range(tte_pkg::CH_UPPER_A, tte_pkg::CH_UPPER_Z)) :
             8'($urandom_range(tte_pkg::CH_LOWER_A, tte_pkg::CH_LOWER_Z)));
    for (int i = 0; i < np; i++) begin
      if (i > 0) begin
        r = $urandom_range(0, 9);
        if (r < 7) push_byte(CH_SEMI);
        else if (r < 8) push_byte(tte_pkg::CH_ESC);
        else push_byte(8'($urandom_range(8'h3A, 8'h40)));
      end
      r = $urandom_range(0, 99);
      if (fin == tte_pkg::CH_J && np == 1 && r < 60) push_number(2);
      else if (r < 80) push_number($urandom_range(0, (i == 0 ? scr_rows : scr_cols) + 2));
      else push_number($urandom_range(0, 999));
    end
    push_byte(fin);
  endtask

  task automatic push_random(input int count);
    int stop_at;
    int r;
    stop_at = n_bytes + count;
    while (n_bytes < stop_at) begin
      r = $urandom_range(0, 99);
      if (r < 50) push_byte(8'($urandom_range(tte_pkg::CH_SPACE, tte_pkg::CH_TILDE)));
      else if (r < 60) push_byte($urandom_range(0, 1) ? tte_pkg::CH_LF : tte_pkg::CH_CR);
      else if (r < 70) push_byte(8'($urandom_range(0, 255)));
      else if (r < 94) push_sequence();
      else begin
        push_byte(tte_pkg::CH_ESC);
        repeat ($urandom_range(1, 4)) push_byte(8'($urandom_range(0, 255)));
      end
    end
  endtask

  task automatic wait_drained();
    while (byte_backlog.size() != 0 || in_valid || expected_cmds.size() != 0)
      @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      tte_pkg::REG_COLUMNS: scr_cols = val;
      tte_pkg::REG_ROWS:    scr_rows = val;
      default:              wrap_col = val;
    endcase
  endtask

  task automatic set_screen(input logic [7:0] cols, input logic [7:0] nrows,
                            input logic [7:0] wrap);
    wait_drained();
    write_reg(tte_pkg::REG_COLUMNS, cols);
    write_reg(tte_pkg::REG_ROWS, nrows);
    write_reg(tte_pkg::REG_WRAP, wrap);
    n_settings++;
    @(negedge clk);
  endtask

  initial begin
    logic [7:0] small_cols;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: field extremes, control bytes, clear, positioning with clamp
    push_byte(tte_pkg::CH_SPACE);
    push_byte(tte_pkg::CH_TILDE);
    push_byte(8'h00);
    push_byte(8'h7F);
    push_byte(8'hFF);
    push_byte(tte_pkg::CH_LF);
    push_byte(tte_pkg::CH_CR);
    push_byte(tte_pkg::CH_ESC);
    push_byte(tte_pkg::CH_BRACKET);
    push_byte(tte_pkg::CH_ZERO + 8'd2);
    push_byte(tte_pkg::CH_J);
    push_byte(tte_pkg::CH_ESC);
    push_byte(tte_pkg::CH_BRACKET);
    push_byte(tte_pkg::CH_NINE);
    push_byte(CH_SEMI);
    push_byte(tte_pkg::CH_NINE);
    push_byte(tte_pkg::CH_NINE);
    push_byte(tte_pkg::CH_H);
    push_byte(tte_pkg::CH_UPPER_Z);
    push_byte(tte_pkg::CH_ESC);
    push_byte(tte_pkg::CH_LOWER_Z);
    push_byte(tte_pkg::CH_NINE);
    push_random(250);

    set_screen(8'd255, 8'd255, 8'd255);
    idle_on = 1'b0;
    push_random(150);

    set_screen(8'd1, 8'd1, 8'd0);
    idle_on = 1'b1;
    push_random(150);

    small_cols = 8'($urandom_range(2, 12));
    set_screen(small_cols, 8'($urandom_range(2, 6)), 8'($urandom_range(0, small_cols + 1)));
    push_random(250);
    // sender holds off until every outstanding command is back
    while (byte_backlog.size() > 120) @(negedge clk);
    hold_sender = 1'b1;
    while (in_valid || expected_cmds.size() != 0) @(negedge clk);
    repeat (3) @(negedge clk);
    hold_sender = 1'b0;

    set_screen(8'($urandom_range(1, 255)), 8'($urandom_range(1, 255)),
               8'($urandom_range(0, 255)));
    push_random(200);

    set_screen(8'($urandom_range(1, 255)), 8'($urandom_range(1, 8)),
               8'($urandom_range(0, 255)));
    push_random(300);

    wait_drained();
    repeat (10) @(negedge clk);
    $display("sent %0d bytes over %0d screen settings", n_bytes, n_settings);
    $display("checked %0d draws, %0d scrolls, %0d clears, %0d errors",
             n_draws, n_scrolls, n_clears, n_errors);
    if (n_errors == 0 && expected_cmds.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

@@ text_terminal_escape_engine.f @@
rtl/tte_pkg.sv
rtl/tte_step.sv
rtl/tte_outq.sv
rtl/text_terminal_escape_engine.sv
test/text_terminal_escape_engine_tb.sv
